// ===== sv/lipa_pkg.sv =====
// Package: shared constants, action codes, register reset values and back-end state type for the arbiter.
package lipa_pkg;
  localparam int NumSources  = 5;
  localparam int NumFields   = 5;
  localparam int TimeBits    = 32;
  localparam int PayloadBits = 64;
  localparam int NumRegs     = 5;
  localparam int SrcW        = 3;
  localparam int FldW        = 3;
  localparam int PrioW       = 3;
  localparam int KindW       = 3;
  localparam int MaskW       = 5;
  localparam int CntW        = 5;

  typedef enum logic [1:0] {
    ACT_SUBMIT    = 2'd0,
    ACT_CLEAR_SRC = 2'd1,
    ACT_CLEAR_ALL = 2'd2,
    ACT_RESOLVE   = 2'd3
  } action_t;

  localparam logic [MaskW-1:0] RegReset [NumRegs] = '{5'd7, 5'd14, 5'd7, 5'd5, 5'd20};

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_COUNT,
    BK_SCAN,
    BK_EMIT
  } bk_state_t;
endpackage

// ===== sv/lipa_front.sv =====
// Front end: accepts requests, applies slot writes and clears, queues resolve jobs.
module lipa_front #(
  parameter int TIME_BITS = lipa_pkg::TimeBits
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    valid,
  output logic                    ready,
  input  logic [1:0]              action,
  input  logic [2:0]              source,
  input  logic [2:0]              target_field,
  input  logic [TIME_BITS-1:0]    now,
  // back end is working on a resolve
  input  logic                    busy,
  // resolve queue toward the back end
  output logic                    q_valid,
  output logic [TIME_BITS-1:0]    q_now,
  input  logic                    q_pop,
  // slot write port
  output logic                    wr_en,
  output logic [$clog2(lipa_pkg::NumSources*lipa_pkg::NumFields)-1:0] wr_idx,
  output logic [lipa_pkg::NumSources*lipa_pkg::NumFields-1:0] slot_valid
);
  localparam int NumSlots = lipa_pkg::NumSources * lipa_pkg::NumFields;
  localparam int IdxW = $clog2(NumSlots);
  localparam int QDepth = 2;

  logic [TIME_BITS-1:0] q_mem [QDepth];
  logic       q_wp, q_rp;
  logic [1:0] q_cnt;
  logic       acc, push;
  logic [NumSlots-1:0] slot_valid_next;

  // no slot change while a resolve is queued or running keeps results exact
  assign ready = (q_cnt == 2'd0) && !busy;
  assign acc   = valid && ready;
  assign push  = acc && (action == lipa_pkg::ACT_RESOLVE);
  assign q_valid = (q_cnt != 2'd0);
  assign q_now   = q_mem[q_rp];

  assign wr_en  = acc && (action == lipa_pkg::ACT_SUBMIT) &&
                  ({29'd0, source} < lipa_pkg::NumSources) &&
                  ({29'd0, target_field} < lipa_pkg::NumFields);
  assign wr_idx = IdxW'({29'd0, source} * lipa_pkg::NumFields + {29'd0, target_field});

  always_comb begin
    slot_valid_next = slot_valid;
    if (wr_en) slot_valid_next[wr_idx] = 1'b1;
    if (acc && action == lipa_pkg::ACT_CLEAR_ALL) slot_valid_next = '0;
    if (acc && action == lipa_pkg::ACT_CLEAR_SRC &&
        {29'd0, source} < lipa_pkg::NumSources) begin
      for (int f = 0; f < lipa_pkg::NumFields; f++)
        slot_valid_next[{29'd0, source} * lipa_pkg::NumFields + f] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      q_wp <= 1'b0;
      q_rp <= 1'b0;
      q_cnt <= 2'd0;
    end else begin
      slot_valid <= slot_valid_next;
      if (push) q_wp <= ~q_wp;
      if (q_pop) q_rp <= ~q_rp;
      q_cnt <= q_cnt + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem[q_wp] <= now;
  end
endmodule

// ===== sv/lipa_back.sv =====
// Back end: slot memory, serial scan of slots and emission of per-field results.
module lipa_back #(
  parameter int TIME_BITS    = lipa_pkg::TimeBits,
  parameter int PAYLOAD_BITS = lipa_pkg::PayloadBits
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  logic [$clog2(lipa_pkg::NumSources*lipa_pkg::NumFields)-1:0] wr_idx,
  input  logic [2:0]              wr_prio,
  input  logic [TIME_BITS-1:0]    wr_stamp,
  input  logic [TIME_BITS-1:0]    wr_lease,
  input  logic [2:0]              wr_kind,
  input  logic [PAYLOAD_BITS-1:0] wr_payload,
  input  logic [lipa_pkg::NumSources*lipa_pkg::NumFields-1:0] slot_valid,
  input  logic [4:0]              allowed [lipa_pkg::NumFields],
  input  logic                    q_valid,
  input  logic [TIME_BITS-1:0]    q_now,
  output logic                    q_pop,
  output logic                    busy,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2:0]              result_field,
  output logic                    has_winner,
  output logic [2:0]              winner_source,
  output logic [PAYLOAD_BITS-1:0] winner_payload,
  output logic [4:0]              loser_mask,
  output logic [4:0]              not_allowed_count,
  output logic [4:0]              kind_mismatch_count,
  output logic                    last
);
  localparam int NS = lipa_pkg::NumSources;
  localparam int NF = lipa_pkg::NumFields;
  localparam int NumSlots = NS * NF;
  localparam int IdxW = $clog2(NumSlots);
  localparam int SW = $clog2(NS);
  localparam int FW = (NF > 1) ? $clog2(NF) : 1;

  typedef struct packed {
    logic [2:0]              prio;
    logic [TIME_BITS-1:0]    stamp;
    logic [TIME_BITS-1:0]    lease;
    logic [2:0]              kind;
    logic [PAYLOAD_BITS-1:0] payload;
  } slot_t;

  slot_t mem [NumSlots];
  slot_t rd;
  logic  rd_vld;

  lipa_pkg::bk_state_t state, state_next;
  logic [TIME_BITS-1:0] now_r;
  logic [IdxW-1:0] rd_addr;   // read address from the issue pointers
  logic [SW-1:0]   rs;        // source of the data in rd
  logic [FW-1:0]   rf;        // field of the data in rd
  logic            rd_live;   // rd holds a scanned slot
  logic            rd_last;   // rd holds the last slot of the pass
  logic [SW-1:0]   is_, is_next;
  logic [FW-1:0]   if_, if_next;
  logic            iss;       // reads still being issued in this pass
  logic            issue_done;
  logic            pass_end, emit_go, last_fld;
  logic [4:0]      na_cnt, mm_cnt;
  logic            have;
  logic [2:0]      w_prio;
  logic [TIME_BITS-1:0] w_stamp;
  logic [SW-1:0]   w_src;
  logic [PAYLOAD_BITS-1:0] w_pay;
  logic [NS-1:0]   elig;
  logic            in_lse, alw, kmatch, beat;

  assign rd_addr = IdxW'(32'(is_) * NF + 32'(if_));

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= '{wr_prio, wr_stamp, wr_lease, wr_kind, wr_payload};
    rd <= mem[rd_addr];
    rd_vld <= slot_valid[rd_addr];
  end

  assign in_lse = (rd.lease == '0) ||
                  ({1'b0, now_r} <= {1'b0, rd.stamp} + {1'b0, rd.lease});
  assign alw    = allowed[rf][rs];
  assign kmatch = ({5'd0, rd.kind} == {{(8-FW){1'b0}}, rf});
  assign beat   = !have || (rd.prio > w_prio) ||
                  (rd.prio == w_prio && rd.stamp > w_stamp) ||
                  (rd.prio == w_prio && rd.stamp == w_stamp && rs > w_src);

  assign pass_end = rd_live && rd_last;
  assign last_fld = (32'(if_) == NF - 1);
  assign emit_go  = (state == lipa_pkg::BK_EMIT) && out_ready;

  // count pass walks slot order, scan pass walks the sources of one field
  always_comb begin
    is_next = is_;
    if_next = if_;
    issue_done = 1'b0;
    if (state == lipa_pkg::BK_COUNT) begin
      if (32'(if_) == NF - 1) begin
        if_next = '0;
        if (32'(is_) == NS - 1) begin
          is_next = '0;
          issue_done = 1'b1;
        end else is_next = is_ + 1'b1;
      end else if_next = if_ + 1'b1;
    end else begin
      if (32'(is_) == NS - 1) begin
        is_next = '0;
        issue_done = 1'b1;
      end else is_next = is_ + 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lipa_pkg::BK_IDLE:  if (q_valid) state_next = lipa_pkg::BK_COUNT;
      lipa_pkg::BK_COUNT: if (pass_end) state_next = lipa_pkg::BK_SCAN;
      lipa_pkg::BK_SCAN:  if (pass_end) state_next = lipa_pkg::BK_EMIT;
      lipa_pkg::BK_EMIT:  if (out_ready) state_next = last_fld ?
                                           lipa_pkg::BK_IDLE : lipa_pkg::BK_SCAN;
      default: state_next = lipa_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state == lipa_pkg::BK_IDLE) && q_valid;
    busy = (state != lipa_pkg::BK_IDLE);
    out_valid = (state == lipa_pkg::BK_EMIT);
    result_field = 3'(if_);
    has_winner = have;
    winner_source = have ? 3'(w_src) : 3'd0;
    winner_payload = have ? w_pay : '0;
    loser_mask = have ? 5'(elig & ~(NS'(1) << w_src)) : 5'd0;
    not_allowed_count = na_cnt;
    kind_mismatch_count = mm_cnt;
    last = last_fld;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lipa_pkg::BK_IDLE;
      iss <= 1'b0;
      rd_live <= 1'b0;
      rd_last <= 1'b0;
      is_ <= '0;
      if_ <= '0;
      na_cnt <= '0;
      mm_cnt <= '0;
      have <= 1'b0;
      elig <= '0;
    end else begin
      state <= state_next;
      rd_live <= iss;
      rd_last <= iss && issue_done;
      if (iss) begin
        rs <= is_;
        rf <= if_;
      end
      // issue pointers: restart per pass, else one read a cycle
      if (q_pop) begin
        now_r <= q_now;
        is_ <= '0;
        if_ <= '0;
        iss <= 1'b1;
      end else if (state == lipa_pkg::BK_COUNT && pass_end) begin
        is_ <= '0;
        if_ <= '0;
        iss <= 1'b1;
      end else if (emit_go && !last_fld) begin
        is_ <= '0;
        if_ <= if_ + 1'b1;
        iss <= 1'b1;
      end else if (iss) begin
        is_ <= is_next;
        if_ <= if_next;
        if (issue_done) iss <= 1'b0;
      end
      if (q_pop) begin
        na_cnt <= '0;
        mm_cnt <= '0;
      end else if (state == lipa_pkg::BK_COUNT && rd_live && rd_vld && in_lse) begin
        if (!alw) na_cnt <= na_cnt + 5'd1;
        else if (!kmatch) mm_cnt <= mm_cnt + 5'd1;
      end
      if ((state == lipa_pkg::BK_COUNT && pass_end) || emit_go) begin
        have <= 1'b0;
        elig <= '0;
      end else if (state == lipa_pkg::BK_SCAN && rd_live && rd_vld && in_lse &&
                   alw && kmatch) begin
        elig[rs] <= 1'b1;
        if (beat) begin
          have <= 1'b1;
          w_prio <= rd.prio;
          w_stamp <= rd.stamp;
          w_src <= rs;
          w_pay <= rd.payload;
        end
      end
    end
  end
endmodule

// ===== sv/leased_intent_priority_arbiter.sv =====
// Top level: leased intent priority arbiter with APB register port.
// Channel | dir | handshake     | payload
// request | in  | valid/ready   | action..now
// result  | out | out_valid/out_ready | result_field..last
// config  | in  | APB psel/penable | allowed masks, 4*i
// Submit and clears do not hold off requests; the next request can follow right away.
// A resolve holds off the next request until its last result is taken: it
// waits in the queue, starts, runs the count pass over all 25 slots
// through the single read port, then per field makes 5 slot reads, lets the
// last read land and shows one output. Requests are held off while a resolve
// is queued or running. Output stalls hold the scan in its output cycle.
// Synchronous active-high reset clears slot valid bits and restores masks.
module leased_intent_priority_arbiter #(
  parameter int TIME_BITS    = lipa_pkg::TimeBits,
  parameter int PAYLOAD_BITS = lipa_pkg::PayloadBits
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [4:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    valid,
  output logic                    ready,
  input  logic [1:0]              action,
  input  logic [2:0]              source,
  input  logic [2:0]              target_field,
  input  logic [2:0]              priority_req,
  input  logic [TIME_BITS-1:0]    stamp,
  input  logic [TIME_BITS-1:0]    lease,
  input  logic [2:0]              payload_kind,
  input  logic [PAYLOAD_BITS-1:0] payload,
  input  logic [TIME_BITS-1:0]    now,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2:0]              result_field,
  output logic                    has_winner,
  output logic [2:0]              winner_source,
  output logic [PAYLOAD_BITS-1:0] winner_payload,
  output logic [4:0]              loser_mask,
  output logic [4:0]              not_allowed_count,
  output logic [4:0]              kind_mismatch_count,
  output logic                    last
);
  localparam int NumSlots = lipa_pkg::NumSources * lipa_pkg::NumFields;

  logic [4:0] allowed [lipa_pkg::NumFields];
  logic q_valid, q_pop, wr_en, busy;
  logic [TIME_BITS-1:0] q_now;
  logic [$clog2(NumSlots)-1:0] wr_idx;
  logic [NumSlots-1:0] slot_valid;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  // allowed masks; fields beyond the register list stay zero
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int f = 0; f < lipa_pkg::NumFields; f++)
        allowed[f] <= (f < lipa_pkg::NumRegs) ? lipa_pkg::RegReset[f] : 5'd0;
    end else if (psel && penable && pwrite) begin
      for (int f = 0; f < lipa_pkg::NumFields; f++)
        if (f < lipa_pkg::NumRegs && 32'(reg_idx) == f) allowed[f] <= pwdata[4:0];
    end
  end

  always_comb begin
    prdata = '0;
    for (int f = 0; f < lipa_pkg::NumFields; f++)
      if (32'(reg_idx) == f) prdata = {27'd0, allowed[f]};
  end

  lipa_front #(.TIME_BITS(TIME_BITS)) u_front (
    .clk, .rst, .valid, .ready, .action, .source, .target_field, .now, .busy,
    .q_valid, .q_now, .q_pop, .wr_en, .wr_idx, .slot_valid
  );

  lipa_back #(.TIME_BITS(TIME_BITS), .PAYLOAD_BITS(PAYLOAD_BITS)) u_back (
    .clk, .rst, .wr_en, .wr_idx, .wr_prio(priority_req), .wr_stamp(stamp),
    .wr_lease(lease), .wr_kind(payload_kind), .wr_payload(payload),
    .slot_valid, .allowed, .q_valid, .q_now, .q_pop, .busy,
    .out_valid, .out_ready, .result_field, .has_winner, .winner_source,
    .winner_payload, .loser_mask, .not_allowed_count, .kind_mismatch_count, .last
  );
endmodule

// ===== sv/lipa_checker.sv =====
// Checker: port-level properties of the arbiter, bound to the top level.
module lipa_checker (
  input logic clk,
  input logic rst,
  input logic ready,
  input logic out_valid,
  input logic out_ready,
  input logic has_winner,
  input logic [4:0] loser_mask,
  input logic [2:0] winner_source,
  input logic pready
);
  a_pready: assert property (@(posedge clk) pready) else $error("pready low");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_nowin: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_winner |-> loser_mask == 5'd0 && winner_source == 3'd0)
    else $error("loser without winner");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !ready) else $error("request taken during resolve");
endmodule

bind leased_intent_priority_arbiter lipa_checker u_chk (
  .clk, .rst, .ready, .out_valid, .out_ready, .has_winner,
  .loser_mask, .winner_source, .pready
);
